### hw/rtl/audio_loop_record_play_unit_assert.svh
// Assertion macros for the audio loop record/play unit.
// Included by the top level; no other dependencies.
`ifndef AUDIO_LOOP_RECORD_PLAY_UNIT_ASSERT_SVH
`define AUDIO_LOOP_RECORD_PLAY_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define ALRP_ASSERT_IMPLIES(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define ALRP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### hw/rtl/alrp_pkg.sv
// Shared constants, types and helper functions of the audio loop record/play unit.
// No dependencies; imported by alrp_if, alrp_ctrl, alrp_mix, alrp_out_fifo and the top level.
`default_nettype none

package alrp_pkg;

   localparam int unsigned LOOP_DEPTH    = 1024 * 1024;
   localparam int unsigned SAMPLE_BITS   = 24;
   localparam int unsigned ADDR_BITS     = $clog2(LOOP_DEPTH);
   localparam int unsigned POS_BITS      = $clog2(LOOP_DEPTH + 1);
   localparam int unsigned PCT_BITS      = 7;
   localparam int unsigned PCT_SCALE     = 100;
   localparam int unsigned GAIN_BITS     = 16;
   localparam int unsigned GAIN_FRAC     = 12;
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 16;

   // percent times position or length
   localparam int unsigned PROD_BITS     = POS_BITS + PCT_BITS;
   // floor(n / 100) = (n * RECIP_MULT) >> RECIP_SHIFT, exact for n below 2**PROD_BITS
   localparam int unsigned RECIP_SHIFT   = PROD_BITS + 7;
   localparam int unsigned RECIP_BITS    = RECIP_SHIFT - 6;
   localparam longint unsigned RECIP_MULT =
      ((64'd1 << RECIP_SHIFT) + PCT_SCALE - 1) / PCT_SCALE;

   localparam int unsigned MIX_BITS      = SAMPLE_BITS + GAIN_BITS;
   localparam int unsigned SUM_BITS      = MIX_BITS - GAIN_FRAC + 1;

   localparam int unsigned FIFO_PTR_BITS = 2;
   localparam int unsigned CREDITS       = 1 << FIFO_PTR_BITS;
   localparam int unsigned CREDIT_BITS   = FIFO_PTR_BITS + 1;

   // input hold-off after reset or a register write, while the window bounds settle
   localparam logic [1:0]                  SETTLE     = 2'd2;

   localparam logic [POS_BITS-1:0]         DEPTH_POS  = POS_BITS'(LOOP_DEPTH);
   localparam logic [POS_BITS-1:0]         LAST_POS   = POS_BITS'(LOOP_DEPTH - 1);
   localparam logic [PROD_BITS-1:0]        PCT100     = PROD_BITS'(PCT_SCALE);
   localparam logic signed [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(4096);
   localparam logic [PCT_BITS-1:0]         END_RESET  = PCT_BITS'(PCT_SCALE);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RECORD_ENABLE = 3'd0,
      CSR_PLAY_ENABLE   = 3'd1,
      CSR_LOOP_GAIN     = 3'd2,
      CSR_WINDOW_START  = 3'd3,
      CSR_WINDOW_END    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_PASS,
      MODE_RECORD,
      MODE_PLAY
   } mode_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic                 we;
      logic                 re;
      logic [ADDR_BITS-1:0] addr;
      sample_type           wdata;
   } ram_cmd_type;

   typedef struct packed {
      logic       valid;
      logic       mix;
      sample_type sample;
   } mix_req_type;

   typedef struct packed {
      logic       valid;
      sample_type sample;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic sample_type sat_sample(input logic signed [SUM_BITS-1:0] value);
      logic [SUM_BITS-SAMPLE_BITS:0] top;
      sample_type                    res;
      top = value[SUM_BITS-1:SAMPLE_BITS-1];
      if ((&top) || !(|top)) begin
         res = value[SAMPLE_BITS-1:0];
      end else if (value[SUM_BITS-1]) begin
         res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/alrp_if.sv
// Valid/ready word channels of the audio loop record/play unit.
// Depends on alrp_pkg.
`default_nettype none

interface alrp_req_if;
   import alrp_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface alrp_rsp_if;
   import alrp_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/alrp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module alrp_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hw/rtl/alrp_ctrl.sv
// Register file, window bound precompute and position sequencer; issues loop RAM accesses.
// Depends on alrp_pkg and alrp_if.
`default_nettype none

module alrp_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   alrp_req_if.sink                           req_ch,
   input  logic                               csr_we,
   input  logic [alrp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [alrp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                               rsp_pop,
   output alrp_pkg::ram_cmd_type              ram_cmd,
   output alrp_pkg::mix_req_type              mix_req,
   output logic signed [alrp_pkg::GAIN_BITS-1:0] gain
);
   import alrp_pkg::*;

   logic                        record_en_ff;
   logic                        play_en_ff;
   logic signed [GAIN_BITS-1:0] gain_ff;
   logic [PCT_BITS-1:0]         start_ff;
   logic [PCT_BITS-1:0]         end_ff;

   logic [PROD_BITS-1:0]        prod_start_ff;
   logic [PROD_BITS-1:0]        prod_end_ff;
   logic [POS_BITS-1:0]         s_pos_ff;
   logic [PROD_BITS-1:0]        s_pos100_ff;
   logic [PROD_BITS+RECIP_BITS-1:0] recip_prod;

   logic [1:0]             settle_ff, settle_in;
   logic [CREDIT_BITS-1:0] credit_ff, credit_in;

   logic                   p_valid_ff, p_valid_in;
   logic                   p_phase_ff, p_phase_in;
   sample_type             p_sample_ff, p_sample_in;
   logic [POS_BITS-1:0]    adj_pos_ff, adj_pos_in;
   logic [PROD_BITS-1:0]   adj100_ff, adj100_in;
   logic [POS_BITS-1:0]    position_ff, position_in;
   logic [PROD_BITS-1:0]   pos100_ff, pos100_in;
   logic [POS_BITS-1:0]    len_ff, len_in;
   mix_req_type            mix_req_ff, mix_req_in;

   mode_type               mode;
   logic                   accept;
   logic                   hit;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         record_en_ff <= 1'b0;
         play_en_ff   <= 1'b0;
         gain_ff      <= GAIN_RESET;
         start_ff     <= '0;
         end_ff       <= END_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RECORD_ENABLE: record_en_ff <= csr_wdata[0];
            CSR_PLAY_ENABLE:   play_en_ff   <= csr_wdata[0];
            CSR_LOOP_GAIN:     gain_ff      <= csr_wdata[GAIN_BITS-1:0];
            CSR_WINDOW_START:  start_ff     <= csr_wdata[PCT_BITS-1:0];
            CSR_WINDOW_END:    end_ff       <= csr_wdata[PCT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // window bounds follow the registers and loop length in up to three registered stages
   assign recip_prod = (PROD_BITS+RECIP_BITS)'(prod_start_ff)
                     * (PROD_BITS+RECIP_BITS)'(RECIP_MULT);

   always_ff @(posedge clock) begin
      prod_start_ff <= PROD_BITS'(start_ff) * PROD_BITS'(len_ff);
      prod_end_ff   <= PROD_BITS'(end_ff) * PROD_BITS'(len_ff);
      s_pos_ff      <= POS_BITS'(recip_prod >> RECIP_SHIFT);
      s_pos100_ff   <= PROD_BITS'(s_pos_ff) * PCT100;
   end

   always_comb begin
      mode = MODE_PASS;
      if (record_en_ff) begin
         mode = MODE_RECORD;
      end else if (play_en_ff) begin
         mode = MODE_PLAY;
      end
   end

   // hold off input until the bounds catch up with a register write, or on no credit
   assign req_ch.ready = (settle_ff == '0) && (credit_ff != CREDIT_BITS'(CREDITS))
                       && (!p_valid_ff || p_phase_ff);
   assign accept = req_ch.valid && req_ch.ready;
   assign hit    = adj_pos_ff < len_ff;

   always_comb begin
      settle_in = settle_ff;
      if (csr_we) begin
         settle_in = SETTLE;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 2'd1;
      end

      credit_in = credit_ff;
      if (accept && !rsp_pop) begin
         credit_in = credit_ff + CREDIT_BITS'(1);
      end else if (!accept && rsp_pop) begin
         credit_in = credit_ff - CREDIT_BITS'(1);
      end
   end

   always_comb begin
      p_valid_in  = p_valid_ff;
      p_phase_in  = p_phase_ff;
      p_sample_in = p_sample_ff;
      adj_pos_in  = adj_pos_ff;
      adj100_in   = adj100_ff;
      position_in = position_ff;
      pos100_in   = pos100_ff;
      len_in      = len_ff;
      mix_req_in  = '{valid: 1'b0, mix: 1'b0, sample: p_sample_ff};
      ram_cmd     = '{we: 1'b0, re: 1'b0, addr: adj_pos_ff[ADDR_BITS-1:0],
                      wdata: p_sample_ff};

      // first step: pull position into the window
      if (p_valid_ff && !p_phase_ff) begin
         p_phase_in = 1'b1;
         adj_pos_in = position_ff;
         adj100_in  = pos100_ff;
         case (mode)
            MODE_RECORD: begin
               if (position_ff == DEPTH_POS) begin
                  adj_pos_in = '0;
                  adj100_in  = '0;
               end
            end
            MODE_PLAY: begin
               if (pos100_ff < prod_start_ff) begin
                  adj_pos_in = s_pos_ff;
                  adj100_in  = s_pos100_ff;
               end else if (pos100_ff > prod_end_ff) begin
                  adj_pos_in = '0;
                  adj100_in  = '0;
               end
            end
            default: ;
         endcase
      end

      // second step: access the loop RAM and advance; else reset the position
      if (p_valid_ff && p_phase_ff) begin
         p_valid_in       = 1'b0;
         p_phase_in       = 1'b0;
         mix_req_in.valid = 1'b1;
         case (mode)
            MODE_RECORD: begin
               ram_cmd.we = 1'b1;
               if (adj_pos_ff == LAST_POS) begin
                  position_in = '0;
                  pos100_in   = '0;
                  len_in      = DEPTH_POS;
               end else begin
                  position_in = adj_pos_ff + POS_BITS'(1);
                  pos100_in   = adj100_ff + PCT100;
                  len_in      = adj_pos_ff + POS_BITS'(1);
               end
            end
            MODE_PLAY: begin
               if (hit) begin
                  ram_cmd.re     = 1'b1;
                  mix_req_in.mix = 1'b1;
                  position_in    = adj_pos_ff + POS_BITS'(1);
                  pos100_in      = adj100_ff + PCT100;
               end else begin
                  position_in = '0;
                  pos100_in   = '0;
               end
            end
            default: begin
               position_in = '0;
               pos100_in   = '0;
            end
         endcase
      end

      if (accept) begin
         p_valid_in  = 1'b1;
         p_phase_in  = 1'b0;
         p_sample_in = req_ch.sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff   <= SETTLE;
         credit_ff   <= '0;
         p_valid_ff  <= 1'b0;
         p_phase_ff  <= 1'b0;
         position_ff <= '0;
         pos100_ff   <= '0;
         len_ff      <= '0;
         mix_req_ff  <= '0;
      end else begin
         settle_ff   <= settle_in;
         credit_ff   <= credit_in;
         p_valid_ff  <= p_valid_in;
         p_phase_ff  <= p_phase_in;
         position_ff <= position_in;
         pos100_ff   <= pos100_in;
         len_ff      <= len_in;
         mix_req_ff  <= mix_req_in;
      end
   end

   always_ff @(posedge clock) begin
      p_sample_ff <= p_sample_in;
      adj_pos_ff  <= adj_pos_in;
      adj100_ff   <= adj100_in;
   end

   assign mix_req = mix_req_ff;
   assign gain    = gain_ff;

endmodule

`default_nettype wire

### hw/rtl/alrp_mix.sv
// Playback mixer: scales the loop sample by the gain, adds it to the input, saturates; else passes the input.
// Depends on alrp_pkg.
`default_nettype none

module alrp_mix (
   input  logic                                  clock,
   input  logic                                  reset,
   input  alrp_pkg::mix_req_type                 mix_req,
   input  logic [alrp_pkg::SAMPLE_BITS-1:0]      ram_rdata,
   input  logic signed [alrp_pkg::GAIN_BITS-1:0] gain,
   output alrp_pkg::push_type                    push
);
   import alrp_pkg::*;

   logic                       s1_valid_ff;
   logic                       s1_mix_ff;
   sample_type                 s1_sample_ff;
   logic signed [MIX_BITS-1:0] prod_ff, prod_in;
   logic signed [SUM_BITS-1:0] sum;
   push_type                   push_ff, push_in;

   assign prod_in = MIX_BITS'($signed(ram_rdata)) * MIX_BITS'(gain);

   // floor of the Q12 product is an arithmetic shift
   assign sum = SUM_BITS'($signed(s1_sample_ff)) + SUM_BITS'(prod_ff >>> GAIN_FRAC);

   always_comb begin
      push_in.valid  = s1_valid_ff;
      push_in.sample = s1_mix_ff ? sat_sample(sum) : s1_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         push_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff   <= mix_req.valid;
         push_ff.valid <= push_in.valid;
      end
      s1_mix_ff      <= mix_req.mix;
      s1_sample_ff   <= mix_req.sample;
      prod_ff        <= prod_in;
      push_ff.sample <= push_in.sample;
   end

   assign push = push_ff;

endmodule

`default_nettype wire

### hw/rtl/alrp_out_fifo.sv
// Output word queue that decouples the mixer from the result channel.
// Depends on alrp_pkg and alrp_if.
`default_nettype none

module alrp_out_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  alrp_pkg::push_type        push,
   alrp_rsp_if.source                rsp_ch,
   output alrp_pkg::fifo_status_type status
);
   import alrp_pkg::*;

   sample_type               entries_ff [CREDITS];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CREDIT_BITS-1:0]   count_ff, count_in;
   logic                     pop;

   assign pop = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + FIFO_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + CREDIT_BITS'(1);
      end else if (!push.valid && pop) begin
         count_in = count_ff - CREDIT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.sample;
      end
   end

   assign rsp_ch.valid      = count_ff != '0;
   assign rsp_ch.sample_out = entries_ff[rd_ptr_ff];
   assign status.full       = count_ff == CREDIT_BITS'(CREDITS);
   assign status.empty      = count_ff == '0;

endmodule

`default_nettype wire

### hw/rtl/audio_loop_record_play_unit.sv
// Channel    Dir  Handshake     Word
// req_ch     in   valid/ready   sample_in, signed 24 bit
// rsp_ch     out  valid/ready   sample_out, signed 24 bit, saturated
// csr_*      in   write enable  csr_index selects register, csr_wdata 16 bit
//
// The position register is first adjusted to the window, then advanced together with
// the loop RAM access; the next word may be taken during that second step.
// A taken word then passes the mix request register, mixer stages s1 and push, and the output queue.
// Up to 4 words in flight; input stalls when all are held by a stalled output.
// After reset and after each register write the input waits for the window bounds,
// while settle_ff counts down. Loop RAM is not cleared; no clearing pass.
//
// Depends on alrp_pkg, alrp_if, alrp_ram, alrp_ctrl, alrp_mix, alrp_out_fifo.
`default_nettype none

`include "audio_loop_record_play_unit_assert.svh"

module audio_loop_record_play_unit (
   input  logic                               clock,
   input  logic                               reset,
   alrp_req_if.sink                           req_ch,
   alrp_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [alrp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [alrp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import alrp_pkg::*;

   ram_cmd_type                 ram_cmd;
   mix_req_type                 mix_req;
   push_type                    push;
   fifo_status_type             fifo_status;
   logic signed [GAIN_BITS-1:0] gain;
   logic [SAMPLE_BITS-1:0]      ram_rdata;
   logic                        rsp_pop;

   assign rsp_pop = rsp_ch.valid && rsp_ch.ready;

   alrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_pop   (rsp_pop),
      .ram_cmd   (ram_cmd),
      .mix_req   (mix_req),
      .gain      (gain)
   );

   alrp_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (LOOP_DEPTH)
   ) u_loop_ram (
      .clock (clock),
      .we    (ram_cmd.we),
      .waddr (ram_cmd.addr),
      .wdata (ram_cmd.wdata),
      .re    (ram_cmd.re),
      .raddr (ram_cmd.addr),
      .rdata (ram_rdata)
   );

   alrp_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .mix_req   (mix_req),
      .ram_rdata (ram_rdata),
      .gain      (gain),
      .push      (push)
   );

   alrp_out_fifo u_out_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .rsp_ch (rsp_ch),
      .status (fifo_status)
   );

   `ALRP_ASSERT_NEXT(a_word_spacing, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "input taken in two consecutive cycles")
   `ALRP_ASSERT_IMPLIES(a_ram_one_access, clock, reset, ram_cmd.we, !ram_cmd.re, "loop RAM read and write in one cycle")
   `ALRP_ASSERT_IMPLIES(a_fifo_room, clock, reset, push.valid, !fifo_status.full, "output queue overrun")

endmodule

`default_nettype wire
